@@ rtl/core/kex_name_list_stream_parser_defines.svh @@
// assertion macros for the key-exchange name list parser
`ifndef KEX_NAME_LIST_STREAM_PARSER_DEFINES_SVH
`define KEX_NAME_LIST_STREAM_PARSER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while in reset
`define KEX_NL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("kex_nl: same-cycle check failed");

// next-cycle implication, sampled on i_clk, off while in reset
`define KEX_NL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("kex_nl: next-cycle check failed");

`endif

@@ rtl/core/kex_nl_pkg.sv @@
// shared types and constants of the key-exchange name list parser
package kex_nl_pkg;

    localparam int DEF_MAX_NAMES = 64;

    localparam logic [2:0] PH_CODE    = 3'd0;
    localparam logic [2:0] PH_COOKIE  = 3'd1;
    localparam logic [2:0] PH_LEN     = 3'd2;
    localparam logic [2:0] PH_BODY    = 3'd3;
    localparam logic [2:0] PH_TRAILER = 3'd4;
    localparam logic [2:0] PH_ERROR   = 3'd5;

    localparam logic [7:0] MSG_CODE     = 8'h14;
    localparam logic [7:0] SEP_CHAR     = 8'h2C;
    localparam logic [4:0] COOKIE_BYTES = 5'd16;
    localparam logic [4:0] LEN_BYTES    = 5'd4;
    localparam logic [3:0] LAST_LIST    = 4'd9;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_COMMA = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_CODE  = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;

    typedef struct packed {
        logic [3:0] list_index;
        logic [6:0] name_index;
        logic [7:0] name_byte;
        logic [1:0] kind;
        logic       name_done;
        logic       list_done;
        logic [1:0] status;
        logic       payload_done;
    } t_result;

endpackage

@@ rtl/core/kex_nl_in_if.sv @@
// input word channel of the name list parser
interface kex_nl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

@@ rtl/core/kex_nl_out_if.sv @@
// result word channel of the name list parser
interface kex_nl_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] list_index;
    logic [6:0] name_index;
    logic [7:0] name_byte;
    logic [1:0] kind;
    logic       name_done;
    logic       list_done;
    logic [1:0] status;
    logic       payload_done;

    modport source (
        output valid, output list_index, output name_index, output name_byte,
        output kind, output name_done, output list_done, output status,
        output payload_done, input ready
    );
    modport sink (
        input valid, input list_index, input name_index, input name_byte,
        input kind, input name_done, input list_done, input status,
        input payload_done, output ready
    );
endinterface

@@ rtl/core/kex_nl_parse.sv @@
// parser state and per-word next-state and result logic
module kex_nl_parse #(
    parameter int MAX_NAMES = kex_nl_pkg::DEF_MAX_NAMES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_data,
    input  logic                i_last,
    output logic                o_emit,
    output kex_nl_pkg::t_result o_res
);

    localparam int NW = $clog2(MAX_NAMES + 1);

    logic [2:0]    r_phase, n_phase;
    logic [4:0]    r_step, n_step;
    logic [31:0]   r_accum, n_accum;
    logic [31:0]   r_left, n_left;
    logic [3:0]    r_list, n_list;
    logic [NW-1:0] r_names, n_names;

    logic       do_end;
    logic [4:0] step_inc;

    always_comb begin
        n_phase  = r_phase;
        n_step   = r_step;
        n_accum  = r_accum;
        n_left   = r_left;
        n_list   = r_list;
        n_names  = r_names;
        do_end   = 1'b0;
        step_inc = r_step + 5'd1;
        o_emit   = 1'b0;

        o_res.list_index   = r_list;
        o_res.name_index   = 7'(r_names);
        o_res.name_byte    = 8'd0;
        o_res.kind         = kex_nl_pkg::KIND_CLOSE;
        o_res.name_done    = 1'b0;
        o_res.list_done    = 1'b0;
        o_res.status       = kex_nl_pkg::ST_OK;
        o_res.payload_done = 1'b0;

        case (r_phase)
            kex_nl_pkg::PH_CODE: begin
                if (i_data != kex_nl_pkg::MSG_CODE) begin
                    o_emit       = 1'b1;
                    o_res.status = kex_nl_pkg::ST_BAD_CODE;
                    n_phase      = kex_nl_pkg::PH_ERROR;
                end else begin
                    n_phase = kex_nl_pkg::PH_COOKIE;
                    n_step  = 5'd0;
                end
            end
            kex_nl_pkg::PH_COOKIE: begin
                n_step = step_inc;
                if (step_inc >= kex_nl_pkg::COOKIE_BYTES) begin
                    n_phase = kex_nl_pkg::PH_LEN;
                    n_step  = 5'd0;
                    n_accum = 32'd0;
                end
            end
            kex_nl_pkg::PH_LEN: begin
                n_accum = {r_accum[23:0], i_data};
                n_step  = step_inc;
                if (step_inc >= kex_nl_pkg::LEN_BYTES) begin
                    n_step = 5'd0;
                    if (n_accum == 32'd0) begin
                        o_emit          = 1'b1;
                        o_res.list_done = 1'b1;
                        do_end          = 1'b1;
                    end else begin
                        n_left  = n_accum;
                        n_names = '0;
                        n_phase = kex_nl_pkg::PH_BODY;
                    end
                end
            end
            kex_nl_pkg::PH_BODY: begin
                o_emit = 1'b1;
                n_left = r_left - 32'd1;
                if (i_data == kex_nl_pkg::SEP_CHAR) begin
                    o_res.kind      = kex_nl_pkg::KIND_COMMA;
                    o_res.name_done = 1'b1;
                    if (r_names < NW'(MAX_NAMES)) begin
                        n_names = r_names + NW'(1);
                    end
                end else begin
                    o_res.kind      = kex_nl_pkg::KIND_CHAR;
                    o_res.name_byte = i_data;
                end
                if (r_left == 32'd1) begin
                    o_res.list_done = 1'b1;
                    o_res.name_done = 1'b1;
                    do_end          = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (do_end) begin
            n_names = '0;
            if (r_list >= kex_nl_pkg::LAST_LIST) begin
                n_list  = kex_nl_pkg::LAST_LIST;
                n_phase = kex_nl_pkg::PH_TRAILER;
            end else begin
                n_list  = r_list + 4'd1;
                n_phase = kex_nl_pkg::PH_LEN;
                n_step  = 5'd0;
                n_accum = 32'd0;
            end
        end

        if (i_last) begin
            o_emit             = 1'b1;
            o_res.payload_done = 1'b1;
            if (n_phase == kex_nl_pkg::PH_TRAILER) begin
                o_res.status = kex_nl_pkg::ST_OK;
            end else if (n_phase == kex_nl_pkg::PH_ERROR) begin
                o_res.status = kex_nl_pkg::ST_BAD_CODE;
            end else begin
                o_res.status = kex_nl_pkg::ST_TRUNCATED;
            end
            n_phase = kex_nl_pkg::PH_CODE;
            n_step  = 5'd0;
            n_accum = 32'd0;
            n_left  = 32'd0;
            n_list  = 4'd0;
            n_names = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= kex_nl_pkg::PH_CODE;
            r_step  <= 5'd0;
            r_accum <= 32'd0;
            r_left  <= 32'd0;
            r_list  <= 4'd0;
            r_names <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_accum <= n_accum;
            r_left  <= n_left;
            r_list  <= n_list;
            r_names <= n_names;
        end
    end

endmodule

@@ rtl/core/kex_nl_out_reg.sv @@
// result register driving the output word channel
module kex_nl_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  kex_nl_pkg::t_result i_res,
    output logic                o_free,
    kex_nl_out_if.source        o_out
);

    logic                r_valid;
    kex_nl_pkg::t_result r_res;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.list_index   = r_res.list_index;
    assign o_out.name_index   = r_res.name_index;
    assign o_out.name_byte    = r_res.name_byte;
    assign o_out.kind         = r_res.kind;
    assign o_out.name_done    = r_res.name_done;
    assign o_out.list_done    = r_res.list_done;
    assign o_out.status       = r_res.status;
    assign o_out.payload_done = r_res.payload_done;

endmodule

@@ rtl/core/kex_name_list_stream_parser.sv @@
// top level of the key-exchange-init name list parser
// Takes a key-exchange-init payload one byte per word and emits one tagged result word per
// name character or comma, plus close and status words as described on the result fields.
// A word can be accepted every cycle while no result waits on a stalled result register; each
// word passes an input register, then the parser logic into the result register.
// Bytes that produce no result retire even while the result register is stalled; a byte
// that produces a result waits in the input register until the result register frees up.
// There is no start-up pass after reset: the block takes words as soon as reset is released.
`include "kex_name_list_stream_parser_defines.svh"

module kex_name_list_stream_parser #(
    parameter int MAX_NAMES = kex_nl_pkg::DEF_MAX_NAMES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    kex_nl_in_if.sink    i_in,
    kex_nl_out_if.source o_out
);

    logic                r_in_valid;
    logic [7:0]          r_in_data;
    logic                r_in_last;
    logic                emit;
    logic                out_free;
    logic                adv;
    kex_nl_pkg::t_result res;

    assign adv       = r_in_valid && (!emit || out_free);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_data <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
    end

    kex_nl_parse #(
        .MAX_NAMES (MAX_NAMES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv),
        .i_data  (r_in_data),
        .i_last  (r_in_last),
        .o_emit  (emit),
        .o_res   (res)
    );

    kex_nl_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && emit),
        .i_res   (res),
        .o_free  (out_free),
        .o_out   (o_out)
    );

    // final byte of a payload always yields a result
    `KEX_NL_ASSERT_NOW(a_last_emits, r_in_valid && r_in_last, emit)
    // a result word never overwrites one that is still waiting
    `KEX_NL_ASSERT_NOW(a_no_overrun, r_in_valid && emit && !out_free, !adv)
    // accepted final byte lands in the input register
    `KEX_NL_ASSERT_NEXT(a_last_captured, i_in.valid && i_in.ready && i_in.last_byte,
        r_in_valid && r_in_last)
    // only character words carry a character
    `KEX_NL_ASSERT_NOW(a_byte_only_char,
        o_out.valid && (o_out.kind != kex_nl_pkg::KIND_CHAR), o_out.name_byte == 8'd0)

endmodule

@@ test/tb_kex_name_list_stream_parser.sv @@
// self-checking testbench of the key-exchange-init name list parser with a byte stream predictor
`timescale 1ns / 100ps

class name_list_tracker;
    kex_nl_pkg::t_result pending_words[$];
    int          errors;
    int          words_checked;
    int          items_noted;
    logic [2:0]  phase;
    logic [4:0]  step_count;
    logic [31:0] length_accum;
    logic [31:0] bytes_left;
    logic [3:0]  list_number;
    logic [6:0]  names_seen;
    logic        name_open;

    function new();
        errors = 0;
        words_checked = 0;
        items_noted = 0;
        clear_state();
    endfunction

    function void clear_state();
        phase = kex_nl_pkg::PH_CODE;
        step_count = '0;
        length_accum = '0;
        bytes_left = '0;
        list_number = '0;
        names_seen = '0;
        name_open = 1'b0;
    endfunction

    function void finish_list();
        names_seen = '0;
        name_open = 1'b0;
        if (list_number >= kex_nl_pkg::LAST_LIST) begin
            list_number = kex_nl_pkg::LAST_LIST;
            phase = kex_nl_pkg::PH_TRAILER;
        end else begin
            list_number++;
            phase = kex_nl_pkg::PH_LEN;
            step_count = '0;
            length_accum = '0;
        end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
        kex_nl_pkg::t_result r;
        bit emit;
        items_noted++;
        emit = 1'b0;
        r = '0;
        r.list_index = list_number;
        r.name_index = names_seen;
        r.kind = kex_nl_pkg::KIND_CLOSE;
        r.status = kex_nl_pkg::ST_OK;
        case (phase)
            kex_nl_pkg::PH_CODE: begin
                if (b != kex_nl_pkg::MSG_CODE) begin
                    emit = 1'b1;
                    r.status = kex_nl_pkg::ST_BAD_CODE;
                    phase = kex_nl_pkg::PH_ERROR;
                end else begin
                    phase = kex_nl_pkg::PH_COOKIE;
                    step_count = '0;
                end
            end
            kex_nl_pkg::PH_COOKIE: begin
                step_count++;
                if (step_count >= kex_nl_pkg::COOKIE_BYTES) begin
                    phase = kex_nl_pkg::PH_LEN;
                    step_count = '0;
                    length_accum = '0;
                end
            end
            kex_nl_pkg::PH_LEN: begin
                length_accum = {length_accum[23:0], b};
                step_count++;
                if (step_count >= kex_nl_pkg::LEN_BYTES) begin
                    step_count = '0;
                    if (length_accum == 0) begin
                        emit = 1'b1;
                        r.list_done = 1'b1;
                        finish_list();
                    end else begin
                        bytes_left = length_accum;
                        names_seen = '0;
                        name_open = 1'b0;
                        phase = kex_nl_pkg::PH_BODY;
                    end
                end
            end
            kex_nl_pkg::PH_BODY: begin
                emit = 1'b1;
                bytes_left--;
                if (b == kex_nl_pkg::SEP_CHAR) begin
                    r.kind = kex_nl_pkg::KIND_COMMA;
                    r.name_done = 1'b1;
                    if (names_seen < kex_nl_pkg::DEF_MAX_NAMES) names_seen++;
                    name_open = 1'b0;
                end else begin
                    r.kind = kex_nl_pkg::KIND_CHAR;
                    r.name_byte = b;
                    name_open = 1'b1;
                end
                if (bytes_left == 0) begin
                    r.list_done = 1'b1;
                    r.name_done = 1'b1;
                    finish_list();
                end
            end
            default: ;
        endcase
        if (last) begin
            emit = 1'b1;
            r.payload_done = 1'b1;
            if (phase == kex_nl_pkg::PH_TRAILER) r.status = kex_nl_pkg::ST_OK;
            else if (phase == kex_nl_pkg::PH_ERROR) r.status = kex_nl_pkg::ST_BAD_CODE;
            else r.status = kex_nl_pkg::ST_TRUNCATED;
            clear_state();
        end
        if (emit) begin
            pending_words = {pending_words, r};
        end
    endfunction

    task report_mismatch(string msg);
        errors++;
        $display("mismatch: %s", msg);
    endtask

    task check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("word %0d %s got %0d expected %0d",
                                      words_checked, name, got, want));
    endtask

    task check_word(kex_nl_pkg::t_result got);
        kex_nl_pkg::t_result want;
        if (pending_words.size() == 0) begin
            report_mismatch($sformatf("word %0d arrived with nothing expected", words_checked));
        end else begin
            want = pending_words.pop_front();
            check_field("list_index", got.list_index, want.list_index);
            check_field("name_index", got.name_index, want.name_index);
            check_field("name_byte", got.name_byte, want.name_byte);
            check_field("kind", got.kind, want.kind);
            check_field("name_done", got.name_done, want.name_done);
            check_field("list_done", got.list_done, want.list_done);
            check_field("status", got.status, want.status);
            check_field("payload_done", got.payload_done, want.payload_done);
        end
        words_checked++;
    endtask
endclass

module tb_kex_name_list_stream_parser;

    localparam int ITEM_TARGET    = 1650;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 16;

    localparam int RX_OPEN    = 0;
    localparam int RX_COIN    = 1;
    localparam int RX_SPARSE  = 2;
    localparam int RX_CADENCE = 3;

    logic clk;
    logic rst_n;

    kex_nl_in_if  in_if();
    kex_nl_out_if out_if();

    name_list_tracker tracker;
    logic [7:0]       payload_q[$];
    int               burst_left;

    kex_name_list_stream_parser u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function void add_byte(input logic [7:0] v);
        payload_q = {payload_q, v};
    endfunction

    task send_word(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_if.valid     <= 1'b1;
        in_if.data_byte <= b;
        in_if.last_byte <= last;
        do @(posedge clk); while (!in_if.ready);
        @(negedge clk);
    endtask

    task send_payload();
        foreach (payload_q[i]) send_word(payload_q[i], i == payload_q.size() - 1);
    endtask

    // ten length-prefixed lists; optional forced corner lists and one oversized length
    function void build_lists(bit force_cases, bit huge_len);
        logic [7:0]  body[$];
        logic [31:0] len32;
        int          crowd_list;
        int          huge_list;
        int          n_names;
        int          name_len;
        crowd_list = force_cases ? 2 : (($urandom_range(0, 5) == 0) ? $urandom_range(0, 9) : -1);
        huge_list = huge_len ? $urandom_range(0, 9) : -1;
        for (int li = 0; li < 10; li++) begin
            body.delete();
            if (!((force_cases && li == 0) || (!force_cases && $urandom_range(0, 7) == 0))) begin
                if (force_cases && li == 9) begin
                    body = {body, 8'h00};
                    body = {body, 8'hFF};
                end
                n_names = (li == crowd_list) ? $urandom_range(66, 72) : $urandom_range(1, 4);
                for (int k = 0; k < n_names; k++) begin
                    if (k > 0 || (force_cases && li == 1) || $urandom_range(0, 7) == 0)
                        body = {body, kex_nl_pkg::SEP_CHAR};
                    name_len = (li == crowd_list) ? $urandom_range(0, 1) : $urandom_range(0, 6);
                    for (int c = 0; c < name_len; c++)
                        body = {body, 8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                               : $urandom_range(8'h61, 8'h7A))};
                end
                if ((force_cases && li == 1) || $urandom_range(0, 3) == 0)
                    body = {body, kex_nl_pkg::SEP_CHAR};
            end
            len32 = 32'(body.size());
            if (li == huge_list) len32[31:24] = 8'($urandom_range(1, 255));
            add_byte(len32[31:24]);
            add_byte(len32[23:16]);
            add_byte(len32[15:8]);
            add_byte(len32[7:0]);
            foreach (body[i]) add_byte(body[i]);
        end
    endfunction

    // receiver stall pattern
    initial begin
        int mode;
        int span;
        int tick;
        out_if.ready = 1'b0;
        tick = 0;
        forever begin
            mode = $urandom_range(RX_OPEN, RX_CADENCE);
            span = $urandom_range(30, 200);
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    RX_OPEN:   out_if.ready <= 1'b1;
                    RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   out_if.ready <= ((tick % 5) < 3);
                endcase
                tick++;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_if.valid && in_if.ready)
                tracker.note_byte(in_if.data_byte, in_if.last_byte);
            if (out_if.valid && out_if.ready)
                tracker.check_word({out_if.list_index, out_if.name_index, out_if.name_byte,
                                    out_if.kind, out_if.name_done, out_if.list_done,
                                    out_if.status, out_if.payload_done});
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle = 0;
            else idle++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int         sel;
        int         n_payload;
        int         cut;
        logic [7:0] b;
        tracker = new();
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        in_if.last_byte = 1'b0;
        burst_left = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // lone right code, lone wrong code, wrong code then ignored bytes, stop inside length
        payload_q = '{kex_nl_pkg::MSG_CODE};
        send_payload();
        payload_q = '{8'h00};
        send_payload();
        payload_q = '{8'hFF, kex_nl_pkg::MSG_CODE, 8'h00, 8'hAB};
        send_payload();
        payload_q = '{kex_nl_pkg::MSG_CODE};
        for (int i = 0; i < 16; i++) add_byte((i % 2) ? 8'hFF : 8'h00);
        add_byte(8'h00);
        send_payload();

        n_payload = 0;
        while (tracker.items_noted < ITEM_TARGET) begin
            sel = $urandom_range(0, 99);
            payload_q.delete();
            if (sel < 8) begin
                do b = 8'($urandom_range(0, 255)); while (b == kex_nl_pkg::MSG_CODE);
                add_byte(b);
                repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
            end else begin
                add_byte(kex_nl_pkg::MSG_CODE);
                repeat (16) add_byte(8'($urandom_range(0, 255)));
                build_lists(n_payload == 0, sel >= 20 && sel < 27);
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)));
                if (sel < 20) begin
                    cut = $urandom_range(1, payload_q.size() - 1);
                    while (payload_q.size() > cut) void'(payload_q.pop_back());
                end
            end
            send_payload();
            n_payload++;
            if (n_payload == 2 || $urandom_range(0, 9) == 0) begin
                in_if.valid <= 1'b0;
                burst_left = 0;
                @(negedge clk);
                while (tracker.pending_words.size() != 0) @(negedge clk);
            end
        end

        in_if.valid <= 1'b0;
        while (tracker.pending_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.pending_words.size() != 0)
            tracker.report_mismatch($sformatf("%0d words never arrived",
                                              tracker.pending_words.size()));
        if (tracker.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
